### rtl/idsc_pkg.sv
package idsc_pkg;

  // Configuration register widths
  localparam int unsigned FRAME_WIDTH_W  = 13;
  localparam int unsigned FRAME_HEIGHT_W = 16;
  localparam int unsigned MODE_W         = 3;
  localparam int unsigned GAIN_W         = 16;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE         = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN         = 2'd3;

  // Register reset values
  localparam logic [FRAME_WIDTH_W-1:0]  FRAME_WIDTH_RST  = 13'd4096;
  localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RST = 16'd1;
  localparam logic [GAIN_W-1:0]         GAIN_RST         = 16'd256;

  // Row position reaches frame height plus one while draining
  localparam int unsigned ROW_W = FRAME_HEIGHT_W + 1;

  // Result word
  localparam int unsigned DERIV_W     = 36;
  localparam int unsigned OUT_TDATA_W = 40;

  // Result queue
  localparam int unsigned FIFO_DEPTH = 8;
  localparam int unsigned FIFO_AW    = 3;

  // Input word kinds
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  typedef enum logic [MODE_W-1:0] {
    MODE_DX  = 3'd0,
    MODE_DY  = 3'd1,
    MODE_DXX = 3'd2,
    MODE_DYY = 3'd3,
    MODE_DXY = 3'd4
  } deriv_mode_e;

  // Per-word stencil control: result request, border replication and frame end
  typedef struct packed {
    logic out_en;
    logic rep_left;
    logic rep_right;
    logic rep_top;
    logic rep_bot;
    logic last;
  } stencil_ctrl_t;

  typedef struct packed {
    logic                      last;
    logic signed [DERIV_W-1:0] deriv;
  } result_t;

endpackage

### rtl/idsc_line_mem.sv
module idsc_line_mem #(
  parameter int unsigned DEPTH  = 4096,
  parameter int unsigned DATA_W = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       rd_en_i,
  input  logic [$clog2(DEPTH)-1:0]   rd_addr_i,
  input  logic                       wr_en_i,
  input  logic [$clog2(DEPTH)-1:0]   wr_addr_i,
  input  logic [DATA_W-1:0]          wr_data_i,
  output logic [DATA_W-1:0]          rd_data_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rd_q;
  logic [DATA_W-1:0] byp_data_q;
  logic              byp_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port, capture a same-edge write for forwarding
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q       <= mem_q[rd_addr_i];
      byp_data_q <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_q <= 1'b0;
    end else if (rd_en_i) begin
      byp_q <= wr_en_i && (wr_addr_i == rd_addr_i);
    end
  end

  // Take the forwarded word where the read collided with a write
  assign rd_data_o = byp_q ? byp_data_q : rd_q;

endmodule

### rtl/image_derivative_stencil_3x3.sv
// 3x3 central-difference derivative of a raster pixel stream with replicated
// borders. Send frame_width x frame_height pixel words in raster order, then
// frame_width + 1 drain words (tuser high) to flush the last row; each result
// leaves frame_width + 1 input words after its pixel, and tlast marks the
// frame's last pixel. The block takes one word per clock cycle while input
// ready stays high. A result passes from the edge that accepts the word
// completing its window through the line-buffer read taken at that edge,
// then the window shift, the stencil sum and the gain multiply into the
// output queue. Both line buffers share one memory, read at acceptance and
// written in the cycle after, with forwarding for a same-column word that
// follows at once. Input ready drops only while eight results are pending
// against the output queue. Derivatives are signed with 10 fractional bits,
// exact for any gain. Change configuration only while no words are in flight.
module image_derivative_stencil_3x3
  import idsc_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned PIXEL_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write port
  input  logic                              cfg_we_i,
  input  logic [CFG_IDX_W-1:0]              cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]             cfg_wdata_i,
  // Pixel stream
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [((PIXEL_BITS+7)/8)*8-1:0]   s_axis_tdata_i,  // pixel
  input  logic                              s_axis_tuser_i,  // command
  // Derivative stream
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  output logic [OUT_TDATA_W-1:0]            m_axis_tdata_o,  // derivative
  output logic                              m_axis_tlast_o   // end_of_frame
);

  localparam int unsigned CW   = $clog2(MAX_WIDTH);
  localparam int unsigned WW   = $clog2(MAX_WIDTH + 1);
  localparam int unsigned WCMP = (WW > FRAME_WIDTH_W) ? WW : FRAME_WIDTH_W;
  localparam int unsigned RCW  = ROW_W + 1;
  localparam int unsigned VW   = PIXEL_BITS + 4;
  localparam int unsigned PW   = VW + GAIN_W + 1;

  // Configuration registers
  logic [FRAME_WIDTH_W-1:0]  fw_q;
  logic [FRAME_HEIGHT_W-1:0] fh_q;
  logic [MODE_W-1:0]         mode_q;
  logic [GAIN_W-1:0]         gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q   <= FRAME_WIDTH_RST;
      fh_q   <= FRAME_HEIGHT_RST;
      mode_q <= MODE_DX;
      gain_q <= GAIN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FRAME_WIDTH:  fw_q   <= cfg_wdata_i[FRAME_WIDTH_W-1:0];
        CFG_FRAME_HEIGHT: fh_q   <= cfg_wdata_i[FRAME_HEIGHT_W-1:0];
        CFG_MODE:         mode_q <= cfg_wdata_i[MODE_W-1:0];
        CFG_GAIN:         gain_q <= cfg_wdata_i[GAIN_W-1:0];
      endcase
    end
  end

  // Clamp width and height to their usable range
  logic [WW-1:0]             w_eff;
  logic [FRAME_HEIGHT_W-1:0] h_eff;

  always_comb begin
    if (fw_q == '0) begin
      w_eff = WW'(1);
    end else if (WCMP'(fw_q) > WCMP'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(fw_q);
    end
    h_eff = (fh_q == '0) ? FRAME_HEIGHT_W'(1) : fh_q;
  end

  // Raster position and acceptance
  logic [CW-1:0]    col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [FIFO_AW:0] pending_q;
  logic             accept;
  logic             pop;

  assign s_axis_tready_o = pending_q < (FIFO_AW + 1)'(FIFO_DEPTH);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  logic [RCW-1:0] r_ext, h_ext;
  logic [WW-1:0]  col_inc;
  logic           col_zero;
  stencil_ctrl_t  ctrl0;

  // Decide result and border handling for the word at the current position
  always_comb begin
    r_ext    = RCW'(row_q);
    h_ext    = RCW'(h_eff);
    col_zero = (col_q == '0);
    col_inc  = WW'(col_q) + WW'(1);
    ctrl0    = '0;
    if (col_zero && r_ext >= RCW'(2) && r_ext < h_ext + RCW'(2)) begin
      // row start: finish the last pixel of the row two back
      ctrl0.out_en    = 1'b1;
      ctrl0.rep_left  = (w_eff == WW'(1));
      ctrl0.rep_right = 1'b1;
      ctrl0.rep_top   = (r_ext == RCW'(2));
      ctrl0.rep_bot   = (r_ext == h_ext + RCW'(1));
      ctrl0.last      = (r_ext == h_ext + RCW'(1));
    end else if (!col_zero && r_ext >= RCW'(1) && r_ext < h_ext + RCW'(1)) begin
      ctrl0.out_en    = 1'b1;
      ctrl0.rep_left  = (col_q == CW'(1));
      ctrl0.rep_right = (WW'(col_q) >= w_eff);
      ctrl0.rep_top   = (r_ext == RCW'(1));
      ctrl0.rep_bot   = (r_ext >= h_ext);
    end
    // advance position, restart after the drain row
    if (col_zero && r_ext >= h_ext + RCW'(1)) begin
      col_d = '0;
      row_d = '0;
    end else if (col_inc >= w_eff) begin
      col_d = '0;
      row_d = row_q + ROW_W'(1);
    end else begin
      col_d = CW'(col_inc);
      row_d = row_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Stage 1: line-buffer read in flight
  logic                  s1_valid_q;
  logic [PIXEL_BITS-1:0] s1_sample_q;
  logic [CW-1:0]         s1_col_q;
  stencil_ctrl_t         s1_ctrl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_sample_q <= (s_axis_tuser_i == CMD_DRAIN) ? '0 : s_axis_tdata_i[PIXEL_BITS-1:0];
      s1_col_q    <= col_q;
      s1_ctrl_q   <= ctrl0;
    end
  end

  // Line buffers: older row in the upper half, previous row in the lower half
  logic [2*PIXEL_BITS-1:0] lb_rd;
  logic [2*PIXEL_BITS-1:0] lb_wr;

  assign lb_wr = {lb_rd[PIXEL_BITS-1:0], s1_sample_q};

  idsc_line_mem #(
    .DEPTH  (MAX_WIDTH),
    .DATA_W (2 * PIXEL_BITS)
  ) u_line_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_addr_i (col_q),
    .wr_en_i   (s1_valid_q),
    .wr_addr_i (s1_col_q),
    .wr_data_i (lb_wr),
    .rd_data_o (lb_rd)
  );

  // Window: [column][row], column 0 oldest, row 0 top
  logic [PIXEL_BITS-1:0] win_q [3][3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < 3; c++) begin
        for (int r = 0; r < 3; r++) begin
          win_q[c][r] <= '0;
        end
      end
    end else if (s1_valid_q) begin
      win_q[0]    <= win_q[1];
      win_q[1]    <= win_q[2];
      win_q[2][0] <= lb_rd[2*PIXEL_BITS-1:PIXEL_BITS];
      win_q[2][1] <= lb_rd[PIXEL_BITS-1:0];
      win_q[2][2] <= s1_sample_q;
    end
  end

  // Stage 2: stencil sum over the shifted window
  logic          s2_valid_q;
  stencil_ctrl_t s2_ctrl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q && s1_ctrl_q.out_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      s2_ctrl_q <= s1_ctrl_q;
    end
  end

  logic [PIXEL_BITS-1:0] lcol [3];
  logic [PIXEL_BITS-1:0] rcol [3];
  logic [1:0]            tsel, bsel;
  logic signed [VW-1:0]  lt, l1, lb, ct, c1, cb, rt, r1, rb;
  logic signed [VW-1:0]  stencil_v;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lcol[i] = s2_ctrl_q.rep_left  ? win_q[1][i] : win_q[0][i];
      rcol[i] = s2_ctrl_q.rep_right ? win_q[1][i] : win_q[2][i];
    end
    tsel = s2_ctrl_q.rep_top ? 2'd1 : 2'd0;
    bsel = s2_ctrl_q.rep_bot ? 2'd1 : 2'd2;
    lt = VW'(lcol[tsel]);
    l1 = VW'(lcol[1]);
    lb = VW'(lcol[bsel]);
    ct = VW'(win_q[1][tsel]);
    c1 = VW'(win_q[1][1]);
    cb = VW'(win_q[1][bsel]);
    rt = VW'(rcol[tsel]);
    r1 = VW'(rcol[1]);
    rb = VW'(rcol[bsel]);
    unique case (deriv_mode_e'(mode_q))
      MODE_DX:  stencil_v = VW'((r1 - l1) <<< 1);
      MODE_DY:  stencil_v = VW'((cb - ct) <<< 1);
      MODE_DXX: stencil_v = VW'((r1 - (c1 <<< 1) + l1) <<< 2);
      MODE_DYY: stencil_v = VW'((cb - (c1 <<< 1) + ct) <<< 2);
      MODE_DXY: stencil_v = VW'(rb - rt - lb + lt);
      default:  stencil_v = '0;
    endcase
  end

  // Stage 3: gain multiply
  logic                 s3_valid_q;
  logic signed [VW-1:0] s3_v_q;
  logic                 s3_last_q;
  logic signed [PW-1:0] product;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_valid_q) begin
      s3_v_q    <= stencil_v;
      s3_last_q <= s2_ctrl_q.last;
    end
  end

  assign product = PW'(s3_v_q) * PW'(signed'({1'b0, gain_q}));

  // Result queue, parts the pipeline from the output handshake
  result_t            fifo_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_AW:0]   fifo_cnt_q;

  assign m_axis_tvalid_o = (fifo_cnt_q != '0);
  assign pop             = m_axis_tvalid_o && m_axis_tready_i;

  always_ff @(posedge clk_i) begin
    if (s3_valid_q) begin
      fifo_q[wr_ptr_q] <= '{last: s3_last_q, deriv: DERIV_W'(product)};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      fifo_cnt_q <= '0;
      pending_q  <= '0;
    end else begin
      if (s3_valid_q) begin
        wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
      end
      fifo_cnt_q <= fifo_cnt_q + (FIFO_AW + 1)'(s3_valid_q) - (FIFO_AW + 1)'(pop);
      // count results owed, from acceptance until taken
      pending_q  <= pending_q + (FIFO_AW + 1)'(accept && ctrl0.out_en)
                              - (FIFO_AW + 1)'(pop);
    end
  end

  assign m_axis_tdata_o = {{(OUT_TDATA_W - DERIV_W){1'b0}}, fifo_q[rd_ptr_q].deriv};
  assign m_axis_tlast_o = fifo_q[rd_ptr_q].last;

endmodule

### test/derivative_checker.sv
`timescale 1ns / 1ps
module derivative_checker
  import idsc_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = 4096
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                   s_axis_tvalid_i,
  input  logic                   s_axis_tready_i,
  input  logic [15:0]            s_axis_tdata_i,   // pixel
  input  logic                   s_axis_tuser_i,   // command
  input  logic                   m_axis_tvalid_i,
  input  logic                   m_axis_tready_i,
  input  logic [OUT_TDATA_W-1:0] m_axis_tdata_i,   // derivative
  input  logic                   m_axis_tlast_i,   // end_of_frame
  output int unsigned            error_count_o,
  output int unsigned            pending_o
);

  // Shadow copies of the configuration registers
  logic [FRAME_WIDTH_W-1:0]  width_q;
  logic [FRAME_HEIGHT_W-1:0] height_q;
  logic [MODE_W-1:0]         mode_q;
  logic [GAIN_W-1:0]         gain_q;

  // Line buffers, 3x3 window (column-major, column 0 oldest) and raster position
  logic [15:0] prev_row_q  [MAX_WIDTH];
  logic [15:0] older_row_q [MAX_WIDTH];
  logic [15:0] win_q [9];
  int unsigned col_q;
  int unsigned row_q;

  result_t     expected_derivs [$];
  int unsigned errors;

  function automatic logic [15:0] win_at(input int unsigned col, input int unsigned row);
    return win_q[(col % 3) * 3 + (row % 3)];
  endfunction

  // Scaled stencil at output (x, y), window columns lc/cc/rc; borders replicate the centre
  function automatic longint scaled_stencil(input int unsigned lc, cc, rc, x, y, w, h);
    int unsigned lft, rgt, up, dn;
    longint      v;
    lft = (x == 0) ? cc : lc;
    rgt = (x + 1 >= w) ? cc : rc;
    up  = (y == 0) ? 1 : 0;
    dn  = (y + 1 >= h) ? 1 : 2;
    case (mode_q)
      MODE_DX:  v = 2 * (longint'(win_at(rgt, 1)) - longint'(win_at(lft, 1)));
      MODE_DY:  v = 2 * (longint'(win_at(cc, dn)) - longint'(win_at(cc, up)));
      MODE_DXX: v = 4 * (longint'(win_at(rgt, 1)) - 2 * longint'(win_at(cc, 1))
                         + longint'(win_at(lft, 1)));
      MODE_DYY: v = 4 * (longint'(win_at(cc, dn)) - 2 * longint'(win_at(cc, 1))
                         + longint'(win_at(cc, up)));
      MODE_DXY: v = longint'(win_at(rgt, dn)) - longint'(win_at(rgt, up))
                  - longint'(win_at(lft, dn)) + longint'(win_at(lft, up));
      default:  v = 0;
    endcase
    return v * longint'(gain_q);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : predict_and_compare
    int unsigned w, h, c, r;
    logic [15:0] sample;
    result_t     res;
    result_t     want;
    bit          produced;
    if (!rst_ni) begin
      width_q  = FRAME_WIDTH_RST;
      height_q = FRAME_HEIGHT_RST;
      mode_q   = MODE_DX;
      gain_q   = GAIN_RST;
      for (int i = 0; i < MAX_WIDTH; i++) begin
        prev_row_q[i]  = '0;
        older_row_q[i] = '0;
      end
      for (int i = 0; i < 9; i++) win_q[i] = '0;
      col_q = 0;
      row_q = 0;
      expected_derivs.delete();
      errors = 0;
      error_count_o <= 0;
      pending_o     <= 0;
    end else begin
      // Track register writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_FRAME_WIDTH:  width_q  = cfg_wdata_i[FRAME_WIDTH_W-1:0];
          CFG_FRAME_HEIGHT: height_q = cfg_wdata_i[FRAME_HEIGHT_W-1:0];
          CFG_MODE:         mode_q   = cfg_wdata_i[MODE_W-1:0];
          CFG_GAIN:         gain_q   = cfg_wdata_i[GAIN_W-1:0];
          default: ;
        endcase
      end

      // Predict the result, if any, of each accepted input word
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        w = width_q;
        if (w == 0) w = 1;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        h = (height_q == 0) ? 1 : height_q;
        c = (col_q >= MAX_WIDTH) ? 0 : col_q;
        r = row_q;
        sample = (s_axis_tuser_i == CMD_DRAIN) ? 16'd0 : s_axis_tdata_i;
        produced = 1'b0;

        // Row start finishes the last pixel of the row two back
        if (c == 0 && r >= 2 && r - 2 < h) begin
          res.deriv = DERIV_W'(scaled_stencil(1, 2, 2, w - 1, r - 2, w, h));
          res.last  = (r - 2 == h - 1);
          produced  = 1'b1;
        end

        // Shift the window and rotate the line buffers
        for (int i = 0; i < 6; i++) win_q[i] = win_q[i + 3];
        win_q[6] = older_row_q[c];
        win_q[7] = prev_row_q[c];
        win_q[8] = sample;
        older_row_q[c] = prev_row_q[c];
        prev_row_q[c]  = sample;

        if (c >= 1 && r >= 1 && r - 1 < h) begin
          res.deriv = DERIV_W'(scaled_stencil(0, 1, 2, c - 1, r - 1, w, h));
          res.last  = 1'b0;
          produced  = 1'b1;
        end
        if (produced) expected_derivs.push_back(res);

        // Advance the raster position; restart once the drain is through
        if (c == 0 && r >= h + 1) begin
          col_q = 0;
          row_q = 0;
        end else if (c + 1 >= w) begin
          col_q = 0;
          row_q = r + 1;
        end else begin
          col_q = c + 1;
          row_q = r;
        end
      end

      // Compare each accepted result word with the oldest prediction
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (expected_derivs.size() == 0) begin
          $error("derivative: expected no word, got %0d",
                 $signed(m_axis_tdata_i[DERIV_W-1:0]));
          errors++;
        end else begin
          want = expected_derivs.pop_front();
          if (m_axis_tdata_i[DERIV_W-1:0] !== want.deriv) begin
            $error("derivative: expected %0d, got %0d", want.deriv,
                   $signed(m_axis_tdata_i[DERIV_W-1:0]));
            errors++;
          end
          if (m_axis_tlast_i !== want.last) begin
            $error("end_of_frame: expected %0b, got %0b", want.last, m_axis_tlast_i);
            errors++;
          end
        end
      end

      error_count_o <= errors;
      pending_o     <= expected_derivs.size();
    end
  end

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import idsc_pkg::*;

  localparam int unsigned MAX_WIDTH     = 4096;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned RANDOM_WORDS  = 600;
  localparam int unsigned CALM_WORDS    = 150;

  logic                   clk_i     = 1'b0;
  logic                   rst_ni    = 1'b0;
  logic                   cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx   = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [15:0]            s_tdata   = '0;
  logic                   s_tuser   = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tlast;
  int unsigned            error_count;
  int unsigned            pending;

  // Stimulus state: register copies, raster position of the next word, traffic shape
  int unsigned cfg_w = FRAME_WIDTH_RST;
  int unsigned cfg_h = FRAME_HEIGHT_RST;
  int unsigned col_t = 0;
  int unsigned row_t = 0;
  int unsigned words_sent = 0;
  int unsigned gap_pct = 25;
  int unsigned noise_pct = 0;
  int unsigned pix_style = 0;
  bit          idle_on = 1'b1;
  bit          hold_req = 1'b0;
  int unsigned stall_cycles = 0;

  always #10 clk_i = ~clk_i;

  image_derivative_stencil_3x3 #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (16)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast)
  );

  derivative_checker #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_i (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_i (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_i  (m_tdata),
    .m_axis_tlast_i  (m_tlast),
    .error_count_o   (error_count),
    .pending_o       (pending)
  );

  function automatic int unsigned eff_w();
    if (cfg_w == 0) return 1;
    if (cfg_w > MAX_WIDTH) return MAX_WIDTH;
    return cfg_w;
  endfunction

  function automatic int unsigned eff_h();
    return (cfg_h == 0) ? 1 : cfg_h;
  endfunction

  // Write one register, then leave the port quiet before returning
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    if (idx == CFG_FRAME_WIDTH) cfg_w = val[FRAME_WIDTH_W-1:0];
    if (idx == CFG_FRAME_HEIGHT) cfg_h = val;
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  // Hold the input until every predicted result is out and the pipeline is empty
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_frame(input logic [15:0] w, h, mode, g);
    wait_idle();
    write_reg(CFG_FRAME_WIDTH, w);
    write_reg(CFG_FRAME_HEIGHT, h);
    write_reg(CFG_MODE, mode);
    write_reg(CFG_GAIN, g);
  endtask

  // Offer one word: a pixel inside the frame, a drain word after it, sometimes swapped
  task automatic send_item();
    logic        cmd;
    logic [15:0] pix;
    cmd = (row_t < eff_h()) ? CMD_PIXEL : CMD_DRAIN;
    if ($urandom_range(0, 99) < noise_pct) cmd = ~cmd;
    case (pix_style)
      0:       pix = 16'($urandom);
      1:       pix = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      2:       pix = 16'($urandom_range(0, 15));
      default: pix = 16'hFFFF - 16'($urandom_range(0, 15));
    endcase
    if (idle_on && $urandom_range(0, 99) < gap_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= pix;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    words_sent++;
    // Advance the raster position as the block will
    if (col_t == 0 && row_t >= eff_h() + 1) begin
      col_t = 0;
      row_t = 0;
    end else if (col_t + 1 >= eff_w()) begin
      col_t = 0;
      row_t++;
    end else begin
      col_t++;
    end
  endtask

  // Send words until the raster position is back at the frame start
  task automatic send_frame();
    do send_item(); while (col_t != 0 || row_t != 0);
  endtask

  task automatic send_items(input int unsigned n);
    repeat (n) send_item();
  endtask

  // Pick a mostly small frame with random settings and traffic shape
  task automatic randomize_frame(input bit allow_idle);
    logic [15:0] w, h, mode, g;
    case ($urandom_range(0, 9))
      0:               w = 0;
      1, 2, 3, 4, 5, 6: w = 16'($urandom_range(1, 8));
      7, 8:            w = 16'($urandom_range(9, 24));
      default:         w = 16'($urandom_range(25, 40));
    endcase
    h = 16'($urandom_range(0, 8));
    mode = ($urandom_range(0, 5) == 0) ? 16'($urandom_range(5, 7))
                                       : 16'($urandom_range(MODE_DX, MODE_DXY));
    case ($urandom_range(0, 3))
      0:       g = 16'h0000;
      1:       g = 16'hFFFF;
      2:       g = GAIN_RST;
      default: g = 16'($urandom);
    endcase
    idle_on   = allow_idle && ($urandom_range(0, 4) != 0);
    gap_pct   = $urandom_range(10, 50);
    noise_pct = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20) : 0;
    pix_style = $urandom_range(0, 3);
    set_frame(w, h, mode, g);
  endtask

  // Receiver: random ready pattern, plus one long hold-off on request
  initial begin : receiver
    bit held;
    held = 1'b0;
    forever begin
      if (hold_req && !held) begin
        held = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles + 1 >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : stimulus
    deriv_mode_e modes [5];
    int unsigned start_words;
    int unsigned reg_pick;
    modes = '{MODE_DX, MODE_DY, MODE_DXX, MODE_DYY, MODE_DXY};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset height, mode and gain on a narrow single row
    write_reg(CFG_FRAME_WIDTH, 16'd4);
    send_frame();

    // Each mode on a small frame of extreme samples at full gain
    pix_style = 1;
    foreach (modes[i]) begin
      set_frame(2, 2, 16'(modes[i]), 16'hFFFF);
      send_frame();
    end

    // Zero width and height fall back to a single pixel
    pix_style = 0;
    set_frame(0, 0, 16'(MODE_DXX), GAIN_RST);
    send_frame();

    // Upper data bits beyond the width register are dropped
    set_frame(16'hE003, 2, 16'(MODE_DY), GAIN_RST);
    send_frame();

    // Drain words inside the frame and pixels where drains are due
    noise_pct = 35;
    set_frame(3, 2, 16'(MODE_DX), GAIN_RST);
    send_frame();
    noise_pct = 0;

    // Height cut below the current row mid-frame
    set_frame(5, 6, 16'(MODE_DYY), 512);
    send_items(17);
    wait_idle();
    write_reg(CFG_FRAME_HEIGHT, 2);
    send_frame();

    // Width cut below the current column mid-frame, gain changed at once
    set_frame(6, 4, 16'(MODE_DXY), 300);
    send_items(10);
    wait_idle();
    write_reg(CFG_FRAME_WIDTH, 3);
    write_reg(CFG_GAIN, 77);
    send_frame();

    // Back-pressure: the receiver holds off while words keep coming
    set_frame(20, 6, 16'(MODE_DX), 1000);
    hold_req = 1'b1;
    send_frame();

    // A tall frame at the narrowest width
    pix_style = 1;
    set_frame(1, 40, 16'(MODE_DYY), 16'hFFFF);
    send_frame();

    // Random frames, some with a register changed mid-frame
    start_words = words_sent;
    while (words_sent - start_words < RANDOM_WORDS) begin
      randomize_frame(1'b1);
      if ($urandom_range(0, 7) == 0) begin
        send_items($urandom_range(1, eff_w() * eff_h()));
        wait_idle();
        reg_pick = $urandom_range(0, 3);
        case (reg_pick)
          0:       write_reg(CFG_FRAME_WIDTH, 16'($urandom_range(1, 12)));
          1:       write_reg(CFG_FRAME_HEIGHT, 16'($urandom_range(1, 8)));
          2:       write_reg(CFG_MODE, 16'($urandom_range(0, 7)));
          default: write_reg(CFG_GAIN, 16'($urandom));
        endcase
      end
      send_frame();
    end

    // Final stretch at full rate on both sides
    idle_on = 1'b0;
    start_words = words_sent;
    while (words_sent - start_words < CALM_WORDS) begin
      randomize_frame(1'b0);
      send_frame();
    end

    wait_idle();
    if (error_count == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
